/* hdl/mms_pkg.sv */
// Shared types and constants for the min/max stack.
// Holds the state encoding, error codes and the controller/datapath link structs.
// Has no dependencies; every other file of the block uses it.
package mms_pkg;

    // Operation codes carried on the cmd field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Error codes reported with each result
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SETTLE,
        S_LOAD,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // apply the operation (writes, counters, error)
        logic do_push;   // push is legal this item
        logic do_pop;    // pop is legal this item
        t_err err;       // error code for this item
        logic finish;    // load the result registers
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic op;        // latched operation code
        logic empty;     // value stack holds nothing
        logic full;      // value stack holds STACK_DEPTH entries
    } t_dp_status;

endpackage

/* hdl/min_max_stack.sv */
// Top level of the min/max stack.
// Instantiates mms_ctrl and mms_dp; uses mms_pkg for the link structs and codes.
//
// LIFO stack of signed words that reports the current minimum and maximum with
// every result, backed by three single-port-style memories (value, minimum and
// maximum stacks) with registered reads. One item is in flight at a time; each
// item runs through the sequence read old tops, update, read new tops, load
// result and deliver, with two registered memory reads in it. Push on a full
// stack and pop on an empty one are flagged in o_error and change nothing. No
// clearing pass is needed after reset.
module min_max_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_popped_value,
    output logic signed [DATA_WIDTH-1:0] o_min_value,
    output logic signed [DATA_WIDTH-1:0] o_max_value,
    output logic                         o_is_empty,
    output logic [1:0]                   o_error
);

    mms_pkg::t_dp_cmd    cmd_bus;
    mms_pkg::t_dp_status status;

    // sequencing
    mms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd_bus   (cmd_bus)
    );

    // storage and arithmetic
    mms_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .o_status       (status),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_popped_value (o_popped_value),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_is_empty     (o_is_empty),
        .o_error        (o_error)
    );

    // input is never taken while a result is still waiting
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // every accepted item presents its result after the EXEC, SETTLE and LOAD states
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##4 o_out_valid)
        else $error("result not presented on schedule");

    // an empty stack reports zero extremes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_min_value == '0 && o_max_value == '0))
        else $error("nonzero extremes on empty stack");

    // a full-stack rejection can never leave the stack empty, and pops nothing
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error == mms_pkg::ERR_FULL) |->
            (!o_is_empty && o_popped_value == '0))
        else $error("inconsistent full-stack result");

endmodule

/* hdl/mms_dp.sv */
// Datapath of the min/max stack: value, minimum and maximum stack memories,
// their counters, the latched item and the result registers.
// Depends on mms_pkg; driven by mms_ctrl through t_dp_cmd.
module mms_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mms_pkg::t_dp_cmd             i_cmd_bus,
    output mms_pkg::t_dp_status          o_status,
    input  logic                         i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic signed [DATA_WIDTH-1:0] o_popped_value,
    output logic signed [DATA_WIDTH-1:0] o_min_value,
    output logic signed [DATA_WIDTH-1:0] o_max_value,
    output logic                         o_is_empty,
    output logic [1:0]                   o_error
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // stack memories, contents undefined until written
    logic signed [DATA_WIDTH-1:0] mem_v   [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] mem_min [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] mem_max [STACK_DEPTH];

    logic [CW-1:0] r_cnt_v, r_cnt_min, r_cnt_max;
    logic [CW-1:0] n_cnt_v, n_cnt_min, n_cnt_max;

    logic signed [DATA_WIDTH-1:0] r_rd_v, r_rd_min, r_rd_max;
    logic                         r_op;
    logic signed [DATA_WIDTH-1:0] r_val;

    logic signed [DATA_WIDTH-1:0] r_popped, r_min_out, r_max_out;
    logic                         r_empty_out;
    mms_pkg::t_err                r_err;

    logic [AW-1:0] top_v, top_min, top_max;
    logic          push_min, push_max, pop_min, pop_max;
    logic          cnt_v_zero, cnt_min_zero, cnt_max_zero;

    // top-of-stack addresses; wrap on empty is never consumed
    assign top_v   = AW'(r_cnt_v   - CW'(1));
    assign top_min = AW'(r_cnt_min - CW'(1));
    assign top_max = AW'(r_cnt_max - CW'(1));

    assign cnt_v_zero   = (r_cnt_v   == '0);
    assign cnt_min_zero = (r_cnt_min == '0);
    assign cnt_max_zero = (r_cnt_max == '0);

    // auxiliary stack decisions, using tops read at the accept edge
    assign push_min = (r_cnt_min != CW'(STACK_DEPTH)) &&
                      (cnt_min_zero || (r_val <= r_rd_min));
    assign push_max = (r_cnt_max != CW'(STACK_DEPTH)) &&
                      (cnt_max_zero || (r_rd_max <= r_val));
    assign pop_min  = !cnt_min_zero && (r_rd_min == r_rd_v);
    assign pop_max  = !cnt_max_zero && (r_rd_max == r_rd_v);

    // counter next values
    always_comb begin
        n_cnt_v   = r_cnt_v;
        n_cnt_min = r_cnt_min;
        n_cnt_max = r_cnt_max;
        if (i_cmd_bus.exec && i_cmd_bus.do_push) begin
            n_cnt_v = r_cnt_v + CW'(1);
            if (push_min) n_cnt_min = r_cnt_min + CW'(1);
            if (push_max) n_cnt_max = r_cnt_max + CW'(1);
        end else if (i_cmd_bus.exec && i_cmd_bus.do_pop) begin
            n_cnt_v = r_cnt_v - CW'(1);
            if (pop_min) n_cnt_min = r_cnt_min - CW'(1);
            if (pop_max) n_cnt_max = r_cnt_max - CW'(1);
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_v   <= '0;
            r_cnt_min <= '0;
            r_cnt_max <= '0;
        end else begin
            r_cnt_v   <= n_cnt_v;
            r_cnt_min <= n_cnt_min;
            r_cnt_max <= n_cnt_max;
        end
    end

    // memories: registered top reads every cycle, writes on push
    always_ff @(posedge i_clk) begin
        r_rd_v   <= mem_v[top_v];
        r_rd_min <= mem_min[top_min];
        r_rd_max <= mem_max[top_max];
        if (i_cmd_bus.exec && i_cmd_bus.do_push) begin
            mem_v[AW'(r_cnt_v)] <= r_val;
            if (push_min) mem_min[AW'(r_cnt_min)] <= r_val;
            if (push_max) mem_max[AW'(r_cnt_max)] <= r_val;
        end
    end

    // item latch, popped value, error and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_op  <= i_cmd;
            r_val <= i_value;
        end
        if (i_cmd_bus.exec) begin
            r_popped <= i_cmd_bus.do_pop ? r_rd_v : '0;
            r_err    <= i_cmd_bus.err;
        end
        if (i_cmd_bus.finish) begin
            r_empty_out <= cnt_v_zero;
            r_min_out   <= (cnt_v_zero || cnt_min_zero) ? '0 : r_rd_min;
            r_max_out   <= (cnt_v_zero || cnt_max_zero) ? '0 : r_rd_max;
        end
    end

    assign o_status.op    = r_op;
    assign o_status.empty = cnt_v_zero;
    assign o_status.full  = (r_cnt_v == CW'(STACK_DEPTH));

    assign o_popped_value = r_popped;
    assign o_min_value    = r_min_out;
    assign o_max_value    = r_max_out;
    assign o_is_empty     = r_empty_out;
    assign o_error        = r_err;

endmodule

/* hdl/mms_ctrl.sv */
// Controller of the min/max stack: sequences read, update, re-read and result.
// Depends on mms_pkg; commands mms_dp and owns both channel handshakes.
module mms_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mms_pkg::t_dp_status i_status,
    output mms_pkg::t_dp_cmd    o_cmd_bus
);

    mms_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd_bus   = '0;
        o_cmd_bus.err = mms_pkg::ERR_NONE;
        unique case (r_state)
            mms_pkg::S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd_bus.capture = i_in_valid;
                if (i_in_valid) n_state = mms_pkg::S_EXEC;
            end
            mms_pkg::S_EXEC: begin
                o_cmd_bus.exec = 1'b1;
                if (i_status.op == mms_pkg::OP_POP) begin
                    o_cmd_bus.do_pop = !i_status.empty;
                    o_cmd_bus.err    = i_status.empty ? mms_pkg::ERR_EMPTY
                                                      : mms_pkg::ERR_NONE;
                end else begin
                    o_cmd_bus.do_push = !i_status.full;
                    o_cmd_bus.err     = i_status.full ? mms_pkg::ERR_FULL
                                                      : mms_pkg::ERR_NONE;
                end
                n_state = mms_pkg::S_SETTLE;
            end
            // new tops are read at the end of this cycle
            mms_pkg::S_SETTLE: begin
                n_state = mms_pkg::S_LOAD;
            end
            mms_pkg::S_LOAD: begin
                o_cmd_bus.finish = 1'b1;
                n_state          = mms_pkg::S_OUT;
            end
            mms_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = mms_pkg::S_IDLE;
            end
            default: begin
                n_state = mms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* bench/tb_min_max_stack.sv */
// Self-checking bench for min_max_stack: drives push/pop items with random bursts and
// output stalls, and checks every result against a mirror of the three stacks.
// Depends on mms_pkg (op and error codes) and the min_max_stack RTL.
module tb_min_max_stack;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int RANDOM_ITEMS = 550;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    // One predicted result of a push or pop
    typedef struct {
        t_word         popped;
        t_word         low;
        t_word         high;
        logic          empty;
        mms_pkg::t_err err;
    } t_stack_outcome;

    // Mirror of the value, minimum and maximum stacks, plus the outcomes still owed
    class t_stack_mirror;
        t_word          values[$];
        t_word          low_marks[$];
        t_word          high_marks[$];
        t_stack_outcome owed[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Apply one accepted item to the mirror and queue its outcome
        function void apply_op(input logic cmd, input t_word v);
            t_stack_outcome r;
            r.popped = '0;
            r.err    = mms_pkg::ERR_NONE;
            if (cmd == mms_pkg::OP_PUSH) begin
                if (values.size() >= STACK_DEPTH) begin
                    r.err = mms_pkg::ERR_FULL;
                end else begin
                    values.push_back(v);
                    if (low_marks.size() == 0 || v <= low_marks[$])
                        low_marks.push_back(v);
                    if (high_marks.size() == 0 || v >= high_marks[$])
                        high_marks.push_back(v);
                end
            end else begin
                if (values.size() == 0) begin
                    r.err = mms_pkg::ERR_EMPTY;
                end else begin
                    r.popped = values.pop_back();
                    // drop an extreme only when it is the value leaving the stack
                    if (low_marks.size() != 0 && low_marks[$] == r.popped)
                        void'(low_marks.pop_back());
                    if (high_marks.size() != 0 && high_marks[$] == r.popped)
                        void'(high_marks.pop_back());
                end
            end
            if (values.size() == 0) begin
                r.low   = '0;
                r.high  = '0;
                r.empty = 1'b1;
            end else begin
                r.low   = low_marks[$];
                r.high  = high_marks[$];
                r.empty = 1'b0;
            end
            owed.push_back(r);
        endfunction

        // Compare one delivered result with the oldest owed outcome
        task check_result(input t_word popped, input t_word low, input t_word high,
                          input logic empty, input logic [1:0] err);
            t_stack_outcome e;
            if (owed.size() == 0) begin
                report("result delivered with nothing outstanding");
            end else begin
                e = owed.pop_front();
                if (popped !== e.popped)
                    report($sformatf("popped_value %0d, want %0d", popped, e.popped));
                if (low !== e.low)
                    report($sformatf("min_value %0d, want %0d", low, e.low));
                if (high !== e.high)
                    report($sformatf("max_value %0d, want %0d", high, e.high));
                if (empty !== e.empty)
                    report($sformatf("is_empty %b, want %b", empty, e.empty));
                if (err !== e.err)
                    report($sformatf("error %0d, want %0d", err, e.err));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = mms_pkg::OP_PUSH;
    logic signed [DATA_WIDTH-1:0] i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_popped_value;
    logic signed [DATA_WIDTH-1:0] o_min_value;
    logic signed [DATA_WIDTH-1:0] o_max_value;
    logic                  o_is_empty;
    logic [1:0]            o_error;

    t_stack_mirror mirror = new();

    // stimulus-side bookkeeping
    int stack_level = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    min_max_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_popped_value(o_popped_value),
        .o_min_value   (o_min_value),
        .o_max_value   (o_max_value),
        .o_is_empty    (o_is_empty),
        .o_error       (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both handshakes at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                mirror.apply_op(i_cmd, i_value);
            if (o_out_valid && i_out_ready)
                mirror.check_result(o_popped_value, o_min_value, o_max_value,
                                    o_is_empty, o_error);
        end
    end

    // Output side: always ready, random ready, or long stalls, in rotating phases
    int rx_cycle = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        case ((rx_cycle / 300) % 3)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 2) != 0);
            default: begin
                if (stall_left == 0) begin
                    i_out_ready <= 1'b1;
                    stall_left = $urandom_range(1, 12);
                end else begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end
            end
        endcase
        rx_cycle++;
    end

    // Present one item, hold it until taken, then maybe open a gap
    task send_item(input logic cmd, input t_word v);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (cmd == mms_pkg::OP_PUSH) begin
            if (stack_level < STACK_DEPTH) stack_level++;
        end else if (stack_level > 0) begin
            stack_level--;
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending until every owed result has come back
    task wait_for_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.owed_count() != 0) @(posedge i_clk);
    endtask

    // Mostly full-range values, many small values (ties on the extremes), some rail values
    function t_word pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_word'($urandom_range(0, 16)) - 8;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_word'($urandom);
        endcase
    endfunction

    initial begin
        int phase_len;
        int extra;
        int phase_no;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop on empty, rails, repeated extremes, unwind, pop on empty again
        send_item(mms_pkg::OP_POP, 32'sh1234_5678);
        send_item(mms_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_item(mms_pkg::OP_PUSH, 32'sh8000_0000);
        send_item(mms_pkg::OP_PUSH, 32'sh8000_0000);
        send_item(mms_pkg::OP_PUSH, -1);
        send_item(mms_pkg::OP_PUSH, 0);
        send_item(mms_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_item(mms_pkg::OP_PUSH, 5);
        repeat (7) send_item(mms_pkg::OP_POP, '1);
        send_item(mms_pkg::OP_POP, '0);
        send_item(mms_pkg::OP_PUSH, 3);
        send_item(mms_pkg::OP_PUSH, 3);
        send_item(mms_pkg::OP_POP, '0);
        send_item(mms_pkg::OP_POP, '0);
        send_item(mms_pkg::OP_POP, '0);

        // Random: fill, drain and mixed phases; first phase fills to full
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ((phase_no == 0) ? 0 : $urandom_range(0, 3))
                0: begin
                    while (stack_level < STACK_DEPTH)
                        send_item(mms_pkg::OP_PUSH, pick_value());
                    extra = $urandom_range(1, 4);
                    repeat (extra) send_item(mms_pkg::OP_PUSH, pick_value());
                end
                1: begin
                    while (stack_level > 0) send_item(mms_pkg::OP_POP, pick_value());
                    extra = $urandom_range(1, 3);
                    repeat (extra) send_item(mms_pkg::OP_POP, pick_value());
                end
                2: begin
                    phase_len = $urandom_range(10, 40);
                    repeat (phase_len)
                        send_item(($urandom_range(0, 9) < 6) ? mms_pkg::OP_PUSH
                                                             : mms_pkg::OP_POP,
                                  pick_value());
                end
                default: begin
                    phase_len = $urandom_range(10, 40);
                    repeat (phase_len)
                        send_item(($urandom_range(0, 9) < 6) ? mms_pkg::OP_POP
                                                             : mms_pkg::OP_PUSH,
                                  pick_value());
                end
            endcase
            // sender holds off until the block has caught up
            if (phase_no == 3 || $urandom_range(0, 5) == 0)
                wait_for_idle();
            phase_no++;
        end

        wait_for_idle();
        repeat (12) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit, well beyond the slowest legal run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mms_pkg.sv
hdl/mms_dp.sv
hdl/mms_ctrl.sv
hdl/min_max_stack.sv
bench/tb_min_max_stack.sv
